>>> hw/rtl/qte_pkg.sv
// Shared types, widths and constants for the quaternion to Euler angle converter.
// No dependencies.
`default_nettype none
package qte_pkg;

  localparam int QW = 16;       // quaternion part width, Q1.14
  localparam int PW = 32;       // pairwise product width, Q2.28
  localparam int EW = 35;       // direction-cosine entry width
  localparam int SW = 30;       // saturated asin argument width
  localparam int VW = 58;       // isqrt radicand width (even)
  localparam int RW = 29;       // isqrt root width
  localparam int MW = 31;       // isqrt remainder width
  localparam int SQ_STEPS = VW / 2;
  localparam int CW = 54;       // CORDIC x/y width
  localparam int ZW = 35;       // CORDIC angle width, Q.30
  localparam int AW = 16;       // output angle width, Q3.13
  localparam int TW = 63;       // timestamp width
  localparam int GW = 11;       // threshold width

  localparam logic signed [ZW-1:0] PI_Q30      = ZW'(64'sd3373259426);
  localparam logic signed [AW-1:0] FULL_PI_Q13 = AW'(25736);
  localparam logic signed [AW-1:0] HALF_PI_Q13 = AW'(12868);
  localparam logic [GW-1:0]        GIMBAL_RST  = GW'(8);

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [ZW-1:0] z;
    logic                 zero;
  } cordic_t;

  typedef struct packed {
    logic [MW-1:0] rem;
    logic [RW-1:0] root;
    logic [VW-1:0] rad;
  } sqrt_t;

  // round(atan(2^-i) * 2^30)
  function automatic logic signed [ZW-1:0] atan_q30(input int i);
    logic signed [ZW-1:0] r;
    case (i)
      0:  r = ZW'(843314857);
      1:  r = ZW'(497837829);
      2:  r = ZW'(263043837);
      3:  r = ZW'(133525159);
      4:  r = ZW'(67021687);
      5:  r = ZW'(33543516);
      6:  r = ZW'(16775851);
      7:  r = ZW'(8388437);
      8:  r = ZW'(4194283);
      9:  r = ZW'(2097149);
      10: r = ZW'(1048576);
      11: r = ZW'(524288);
      12: r = ZW'(262144);
      13: r = ZW'(131072);
      14: r = ZW'(65536);
      15: r = ZW'(32768);
      16: r = ZW'(16384);
      17: r = ZW'(8192);
      18: r = ZW'(4096);
      19: r = ZW'(2048);
      20: r = ZW'(1024);
      21: r = ZW'(512);
      22: r = ZW'(256);
      23: r = ZW'(128);
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q.30 angle to Q3.13, halves round up, then clamp to +/-lim
  function automatic logic signed [AW-1:0] to_q13(input logic signed [ZW-1:0] a,
                                                  input logic signed [AW-1:0] lim);
    logic signed [ZW:0]    t;
    logic signed [ZW-17:0] r;
    logic signed [AW-1:0]  o;
    t = (ZW+1)'(a) + (ZW+1)'(65536);
    r = (ZW-16)'(t >>> 17);
    if (r > (ZW-16)'(lim))       o = lim;
    else if (r < -(ZW-16)'(lim)) o = -lim;
    else                         o = AW'(r);
    return o;
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/qte_delay.sv
// Register line that keeps side data aligned with the pipeline.
// No dependencies.
`default_nettype none
module qte_delay #(
  parameter int W = 8,
  parameter int D = 1
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] din,
  output logic      [W-1:0] dout
);
  logic [W-1:0] tap [0:D-1];

  always_ff @(posedge clk) begin
    if (en) begin
      tap[0] <= din;
      for (int i = 1; i < D; i++) tap[i] <= tap[i-1];
    end
  end

  assign dout = tap[D-1];
endmodule
`default_nettype wire

>>> hw/rtl/qte_sqrt_cell.sv
// One digit step of the restoring integer square root.
// Depends on qte_pkg.
`default_nettype none
module qte_sqrt_cell (
  input  wire logic           clk,
  input  wire logic           en,
  input  wire qte_pkg::sqrt_t din,
  output qte_pkg::sqrt_t      dout
);
  import qte_pkg::*;

  logic [MW+1:0] rem2;
  logic [MW+1:0] test;
  sqrt_t         nxt;

  // bring down two radicand bits, try root*4+1
  always_comb begin
    rem2 = {din.rem, din.rad[VW-1 -: 2]};
    test = (MW+2)'({din.root, 2'b01});
    nxt.rad = {din.rad[VW-3:0], 2'b00};
    if (rem2 >= test) begin
      nxt.rem  = MW'(rem2 - test);
      nxt.root = {din.root[RW-2:0], 1'b1};
    end else begin
      nxt.rem  = MW'(rem2);
      nxt.root = {din.root[RW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/qte_cordic_cell.sv
// One vectoring CORDIC micro-rotation with its fixed shift.
// Depends on qte_pkg.
`default_nettype none
module qte_cordic_cell #(
  parameter int IDX = 0
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire qte_pkg::cordic_t din,
  output qte_pkg::cordic_t      dout
);
  import qte_pkg::*;

  logic signed [CW-1:0] dx, dy;
  cordic_t              nxt;

  always_comb begin
    dx = din.x >>> IDX;
    dy = din.y >>> IDX;
    nxt.zero = din.zero;
    if (!din.y[CW-1]) begin
      nxt.x = din.x + dy;
      nxt.y = din.y - dx;
      nxt.z = din.z + atan_q30(IDX);
    end else begin
      nxt.x = din.x - dy;
      nxt.y = din.y + dx;
      nxt.z = din.z - atan_q30(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout <= nxt;
  end
endmodule
`default_nettype wire

>>> hw/rtl/qte_cordic.sv
// atan2(y, x) as a pre-rotation stage followed by a row of CORDIC cells.
// Depends on qte_pkg, qte_cordic_cell.
`default_nettype none
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic signed [qte_pkg::EW-1:0] y,
  input  wire logic signed [qte_pkg::EW-1:0] x,
  output logic signed [qte_pkg::ZW-1:0]    angle
);
  import qte_pkg::*;

  cordic_t              st [0:STAGES];
  logic signed [CW-1:0] xs, ys;

  assign xs = CW'(x) <<< 16;
  assign ys = CW'(y) <<< 16;

  // left half plane: rotate by pi first
  always_ff @(posedge clk) begin
    if (en) begin
      st[0].zero <= (x == '0) && (y == '0);
      if (x[EW-1]) begin
        st[0].x <= -xs;
        st[0].y <= -ys;
        st[0].z <= y[EW-1] ? -PI_Q30 : PI_Q30;
      end else begin
        st[0].x <= xs;
        st[0].y <= ys;
        st[0].z <= '0;
      end
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_cell
    qte_cordic_cell #(.IDX(i)) u_cell (
      .clk (clk),
      .en  (en),
      .din (st[i]),
      .dout(st[i+1])
    );
  end

  assign angle = st[STAGES].zero ? '0 : st[STAGES].z;
endmodule
`default_nettype wire

>>> hw/rtl/quaternion_to_euler_angles_top.sv
// Top level of the quaternion to ZYX Euler angle converter.
// Depends on qte_pkg, qte_delay, qte_sqrt_cell, qte_cordic.
//
// Takes one item and gives one result item per clock, unless the pipeline
// holds for a result waiting on out_stall; in_stall follows that condition.
// Input capture, pairwise products, cosine entries and the radicand register
// feed a 29-cell square-root chain for the pitch cosine, then five parallel
// CORDIC rows of CORDIC_STAGES+1 cells (roll, pitch, yaw and both gimbal-lock
// yaws), then angle rounding and the lock select. The user must write
// gimbal_threshold through cfg_wen/cfg_wdata while idle; no logic enforces it.
`default_nettype none
module quaternion_to_euler_angles_top #(
  parameter int CORDIC_STAGES = 16
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_wen,
  input  wire logic [qte_pkg::GW-1:0]        cfg_wdata,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic signed [qte_pkg::QW-1:0] quat_w,
  input  wire logic signed [qte_pkg::QW-1:0] quat_x,
  input  wire logic signed [qte_pkg::QW-1:0] quat_y,
  input  wire logic signed [qte_pkg::QW-1:0] quat_z,
  input  wire logic [qte_pkg::TW-1:0]        sample_time,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [qte_pkg::AW-1:0]      roll_angle,
  output logic signed [qte_pkg::AW-2:0]      pitch_angle,
  output logic signed [qte_pkg::AW-1:0]      yaw_angle,
  output logic                               gimbal_lock,
  output logic [qte_pkg::TW-1:0]             out_time
);
  import qte_pkg::*;

  localparam int LAT  = CORDIC_STAGES + 36;
  localparam int XW   = 6 * EW + SW;
  localparam int SDLY = SQ_STEPS + 1;

  logic            en;
  logic [LAT-1:0]  vld;
  logic [GW-1:0]   gimbal_threshold;

  assign en       = !(vld[LAT-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = vld[LAT-1];

  // configuration and valid line
  always_ff @(posedge clk) begin
    if (rst) begin
      gimbal_threshold <= GIMBAL_RST;
      vld <= '0;
    end else begin
      if (cfg_wen) gimbal_threshold <= cfg_wdata;
      if (en) vld <= {vld[LAT-2:0], in_valid};
    end
  end

  // input capture
  logic signed [QW-1:0] qa, qb, qc, qd;
  always_ff @(posedge clk) begin
    if (en) begin
      qa <= quat_w; qb <= quat_x; qc <= quat_y; qd <= quat_z;
    end
  end

  // pairwise products, Q2.28
  logic signed [PW-1:0] aa, ab, ac, ad, bb, bc, bd, cc, cd, dd;
  always_ff @(posedge clk) begin
    if (en) begin
      aa <= qa * qa; ab <= qa * qb; ac <= qa * qc; ad <= qa * qd;
      bb <= qb * qb; bc <= qb * qc; bd <= qb * qd;
      cc <= qc * qc; cd <= qc * qd; dd <= qd * qd;
    end
  end

  // direction-cosine entries and the clamped asin argument
  logic signed [EW-1:0] c20_w, s_w;
  logic signed [SW-1:0] s_sat;
  logic signed [EW-1:0] c00, c02, c10, c12, c21, c22;
  logic signed [SW-1:0] s_arg;

  always_comb begin
    c20_w = (EW'(bd) - EW'(ac)) <<< 1;
    s_w   = -c20_w;
    if (s_w > EW'(64'sd268435456))       s_sat = SW'(64'sd268435456);
    else if (s_w < -EW'(64'sd268435456)) s_sat = -SW'(64'sd268435456);
    else                                  s_sat = SW'(s_w);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      c00   <= EW'(aa) + EW'(bb) - EW'(cc) - EW'(dd);
      c22   <= EW'(aa) - EW'(bb) - EW'(cc) + EW'(dd);
      c02   <= (EW'(ac) + EW'(bd)) <<< 1;
      c10   <= (EW'(bc) + EW'(ad)) <<< 1;
      c12   <= (EW'(cd) - EW'(ab)) <<< 1;
      c21   <= (EW'(ab) + EW'(cd)) <<< 1;
      s_arg <= s_sat;
    end
  end

  // radicand 2^56 - s*s
  logic [2*SW-1:0] ss;
  logic [VW-1:0]   rad;
  assign ss = unsigned'((2*SW)'(s_arg) * (2*SW)'(s_arg));
  always_ff @(posedge clk) begin
    if (en) rad <= (VW'(1) << 56) - VW'(ss);
  end

  // square-root chain
  sqrt_t sq [0:SQ_STEPS];
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;
  assign sq[0].rad  = rad;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sqrt
    qte_sqrt_cell u_sq (
      .clk (clk),
      .en  (en),
      .din (sq[k]),
      .dout(sq[k+1])
    );
  end

  // keep the other entries beside the root
  logic [XW-1:0] ent_d;
  logic signed [EW-1:0] d00, d02, d10, d12, d21, d22, ds, dcs;
  logic signed [SW-1:0] ds_n;

  qte_delay #(.W(XW), .D(SDLY)) u_ent (
    .clk (clk),
    .en  (en),
    .din ({c00, c02, c10, c12, c21, c22, s_arg}),
    .dout(ent_d)
  );

  assign {d00, d02, d10, d12, d21, d22, ds_n} = ent_d;
  assign ds  = EW'(ds_n);
  assign dcs = EW'(sq[SQ_STEPS].root);

  // five atan2 rows
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw, z_up, z_dn;

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_roll (
    .clk(clk), .en(en), .y(d21), .x(d22), .angle(z_roll));
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_pitch (
    .clk(clk), .en(en), .y(ds), .x(dcs), .angle(z_pitch));
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_yaw (
    .clk(clk), .en(en), .y(d10), .x(d00), .angle(z_yaw));
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_up (
    .clk(clk), .en(en), .y(d12), .x(d02), .angle(z_up));
  qte_cordic #(.STAGES(CORDIC_STAGES)) u_dn (
    .clk(clk), .en(en), .y(-d12), .x(-d02), .angle(z_dn));

  // round to Q3.13
  logic signed [AW-1:0] r_roll, r_pitch, r_yaw, r_up, r_dn;
  always_ff @(posedge clk) begin
    if (en) begin
      r_roll  <= to_q13(z_roll, FULL_PI_Q13);
      r_pitch <= to_q13(z_pitch, HALF_PI_Q13);
      r_yaw   <= to_q13(z_yaw, FULL_PI_Q13);
      r_up    <= to_q13(z_up, FULL_PI_Q13);
      r_dn    <= to_q13(z_dn, FULL_PI_Q13);
    end
  end

  // gimbal-lock window test against +/- pi/2
  logic signed [AW:0] du, dl;
  logic [AW-1:0]      du_abs, dl_abs;
  logic               lock_up, lock_dn;

  always_comb begin
    du = (AW+1)'(r_pitch) - (AW+1)'(HALF_PI_Q13);
    dl = (AW+1)'(r_pitch) + (AW+1)'(HALF_PI_Q13);
    du_abs = du[AW] ? AW'(-du) : AW'(du);
    dl_abs = dl[AW] ? AW'(-dl) : AW'(dl);
    lock_up = du_abs < AW'(gimbal_threshold);
    lock_dn = dl_abs < AW'(gimbal_threshold);
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      pitch_angle <= (AW-1)'(r_pitch);
      if (lock_up) begin
        roll_angle  <= '0;
        yaw_angle   <= r_up;
        gimbal_lock <= 1'b1;
      end else if (lock_dn) begin
        roll_angle  <= '0;
        yaw_angle   <= r_dn;
        gimbal_lock <= 1'b1;
      end else begin
        roll_angle  <= r_roll;
        yaw_angle   <= r_yaw;
        gimbal_lock <= 1'b0;
      end
    end
  end

  // timestamp rides alongside
  qte_delay #(.W(TW), .D(LAT)) u_time (
    .clk (clk),
    .en  (en),
    .din (sample_time),
    .dout(out_time)
  );
endmodule
`default_nettype wire

>>> bench/qte_checker.sv
// Checker for the quaternion to Euler angle converter: watches both channels,
// predicts each result item and compares the whole item at once.
// Depends on qte_pkg for widths.
module qte_checker #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_wen,
  input  logic [qte_pkg::GW-1:0]        cfg_wdata,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic signed [qte_pkg::QW-1:0] quat_w,
  input  logic signed [qte_pkg::QW-1:0] quat_x,
  input  logic signed [qte_pkg::QW-1:0] quat_y,
  input  logic signed [qte_pkg::QW-1:0] quat_z,
  input  logic [qte_pkg::TW-1:0]        sample_time,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic signed [qte_pkg::AW-1:0] roll_angle,
  input  logic signed [qte_pkg::AW-2:0] pitch_angle,
  input  logic signed [qte_pkg::AW-1:0] yaw_angle,
  input  logic                          gimbal_lock,
  input  logic [qte_pkg::TW-1:0]        out_time,
  output int                            fail_count,
  output int                            pending
);
  typedef struct packed {
    logic signed [15:0] roll;
    logic signed [14:0] pitch;
    logic signed [15:0] yaw;
    logic               lock;
    logic [62:0]        stamp;
  } angles_t;

  localparam longint PI30 = 64'sd3373259426;
  localparam longint HALF13 = 12868;
  localparam longint FULL13 = 25736;

  longint atan_steps [24] = '{843314857, 497837829, 263043837, 133525159, 67021687,
    33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
    131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128};

  angles_t expected_angles [$];
  longint  lock_window;

  assign pending = expected_angles.size();

  // vectoring CORDIC, Q.30 angle
  function automatic longint cordic_atan2(longint yi, longint xi);
    longint xv, yv, ang, dx, dy;
    ang = 0;
    if (xi == 0 && yi == 0) return 0;
    xv = xi * 65536;
    yv = yi * 65536;
    if (xv < 0) begin
      ang = (yv >= 0) ? PI30 : -PI30;
      xv = -xv;
      yv = -yv;
    end
    for (int i = 0; i < STAGES && i < 24; i++) begin
      dx = xv >>> i;
      dy = yv >>> i;
      if (yv >= 0) begin
        xv += dy; yv -= dx; ang += atan_steps[i];
      end else begin
        xv -= dy; yv += dx; ang -= atan_steps[i];
      end
    end
    return ang;
  endfunction

  function automatic longint round_q13(longint a, longint lim);
    longint r;
    r = (a + 65536) >>> 17;
    if (r > lim) r = lim;
    if (r < -lim) r = -lim;
    return r;
  endfunction

  function automatic longint floor_sqrt(longint v);
    longint r, lo, hi, m;
    lo = 0;
    hi = 64'd1 << 29;
    while (lo < hi) begin
      m = (lo + hi + 1) / 2;
      if (m * m <= v) lo = m; else hi = m - 1;
    end
    r = lo;
    return r;
  endfunction

  function automatic angles_t convert_attitude(longint a, longint b, longint c,
                                               longint d, logic [62:0] stamp);
    angles_t o;
    longint c00, c02, c10, c12, c20, c21, c22, s, cs, roll, pitch, yaw, du, dl;
    c00 = a*a + b*b - c*c - d*d;
    c02 = 2 * (a*c + b*d);
    c10 = 2 * (b*c + a*d);
    c12 = 2 * (c*d - a*b);
    c20 = 2 * (b*d - a*c);
    c21 = 2 * (a*b + c*d);
    c22 = a*a - b*b - c*c + d*d;
    s = -c20;
    if (s > (64'sd1 << 28)) s = 64'sd1 << 28;
    if (s < -(64'sd1 << 28)) s = -(64'sd1 << 28);
    cs = floor_sqrt((64'sd1 << 56) - s * s);
    roll = round_q13(cordic_atan2(c21, c22), FULL13);
    pitch = round_q13(cordic_atan2(s, cs), HALF13);
    yaw = round_q13(cordic_atan2(c10, c00), FULL13);
    du = pitch - HALF13; if (du < 0) du = -du;
    dl = pitch + HALF13; if (dl < 0) dl = -dl;
    o.lock = 1'b0;
    if (du < lock_window) begin
      roll = 0; yaw = round_q13(cordic_atan2(c12, c02), FULL13); o.lock = 1'b1;
    end else if (dl < lock_window) begin
      roll = 0; yaw = round_q13(cordic_atan2(-c12, -c02), FULL13); o.lock = 1'b1;
    end
    o.roll = 16'(roll);
    o.pitch = 15'(pitch);
    o.yaw = 16'(yaw);
    o.stamp = stamp;
    return o;
  endfunction

  // predict on input accept, compare on output accept
  always @(posedge clk) begin
    angles_t got, want;
    if (rst) begin
      lock_window <= 8;
      fail_count <= 0;
      expected_angles.delete();
    end else begin
      if (cfg_wen) lock_window <= cfg_wdata;
      if (in_valid && !in_stall)
        expected_angles.push_back(convert_attitude(quat_w, quat_x, quat_y, quat_z,
                                                   sample_time));
      if (out_valid && !out_stall) begin
        got = '{roll_angle, pitch_angle, yaw_angle, gimbal_lock, out_time};
        if (expected_angles.size() == 0) begin
          $display("%0t: unexpected item %p", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_angles.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected %p actual %p", $time, want, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> bench/quaternion_to_euler_angles_top_tb.sv
// Testbench top for the quaternion to Euler angle converter: clock, reset,
// threshold phases and quaternion stimulus. Depends on qte_checker and the RTL.
module quaternion_to_euler_angles_top_tb;
  localparam int LATENCY = 16 + 36;
  localparam int STALL_LIMIT = 4000;

  logic clk, rst, cfg_wen, in_valid, out_stall;
  logic [10:0] cfg_wdata;
  logic signed [15:0] quat_w, quat_x, quat_y, quat_z;
  logic [62:0] sample_time;
  logic in_stall, out_valid, gimbal_lock;
  logic signed [15:0] roll_angle, yaw_angle;
  logic signed [14:0] pitch_angle;
  logic [62:0] out_time;
  int fail_count, pending, idle_cycles, out_wait;

  quaternion_to_euler_angles_top u_top (.*);

  qte_checker #(.STAGES(16)) u_checker (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // watchdog on cycles with no accepted item
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // receiver wait per result item, drawn at random
  always @(posedge clk) begin : rx_wait
    int w;
    w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
    if (rst) begin
      out_wait <= 0;
      out_stall <= 0;
    end else if (out_valid && !out_stall) begin
      out_wait <= w;
      out_stall <= (w != 0);
    end else if (out_valid) begin
      out_wait <= out_wait - 1;
      out_stall <= (out_wait > 1);
    end
  end

  task automatic send_quat(logic [15:0] w, logic [15:0] x, logic [15:0] y,
                           logic [15:0] z);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    quat_w <= w; quat_x <= x; quat_y <= y; quat_z <= z;
    sample_time <= {$urandom, $urandom};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic set_window(logic [10:0] v);
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    cfg_wen <= 1; cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 0;
  endtask

  // unit quaternion from a random direction, scaled to Q1.14
  task automatic send_unit();
    real a, b, c, d, n;
    a = $itor($signed($urandom)) ; b = $itor($signed($urandom));
    c = $itor($signed($urandom)) ; d = $itor($signed($urandom));
    n = $sqrt(a*a + b*b + c*c + d*d) + 1.0;
    send_quat(16'($rtoi(a/n*16384)), 16'($rtoi(b/n*16384)),
              16'($rtoi(c/n*16384)), 16'($rtoi(d/n*16384)));
  endtask

  // near gimbal lock: pitch close to +/-90 deg
  task automatic send_near_lock();
    int e, f, sgn;
    e = $urandom_range(0, 300); f = $urandom_range(0, 300);
    sgn = $urandom_range(0, 1) ? 1 : -1;
    // w and y of near-equal size, x and z small, so s = -c20 = 2(ac-bd) is near +/-1
    send_quat(16'(11585 + e), 16'($signed(16'($urandom_range(0, 400))) - 200),
              16'(sgn * (11585 - f)), 16'($signed(16'($urandom_range(0, 400))) - 200));
  endtask

  initial begin
    logic [10:0] windows [5] = '{0, 1024, 8, 200, 2047};
    rst = 1; cfg_wen = 0; cfg_wdata = 0; in_valid = 0;
    quat_w = 0; quat_x = 0; quat_y = 0; quat_z = 0; sample_time = 0;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed: axes, extremes, zero vector, lock points
    send_quat(0, 0, 0, 0);
    send_quat(16384, 0, 0, 0);
    send_quat(-16384, 0, 0, 0);
    send_quat(0, 16384, 0, 0);
    send_quat(0, 0, 16384, 0);
    send_quat(0, 0, 0, 16384);
    send_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff);
    send_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000);
    send_quat(16'h8000, 16'h7fff, 16'h0000, 16'hffff);
    send_quat(11585, 0, 11585, 0);
    send_quat(11585, 0, -11585, 0);
    send_quat(11585, 1000, 11585, -1000);
    send_quat(-11585, 0, 11585, 0);
    send_quat(8192, 8192, 8192, 8192);
    send_quat(-8192, 8192, -8192, 8192);
    foreach (windows[p]) begin
      set_window(windows[p]);
      for (int i = 0; i < 340; i++) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3, 4: send_unit();
          5, 6: send_near_lock();
          7: send_quat(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
          default: send_quat(16'($urandom_range(0, 32768)) - 16'sd16384,
                             16'($urandom_range(0, 32768)) - 16'sd16384,
                             16'($urandom_range(0, 32768)) - 16'sd16384,
                             16'($urandom_range(0, 32768)) - 16'sd16384);
        endcase
      end
    end
    in_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
